@@ design/stm_pkg.sv @@
`default_nettype none

package stm_pkg;

  // map geometry
  localparam int MapDepth = 256;
  localparam int MapAw    = 8;
  localparam int ByteW    = 8;
  localparam int WordW    = 32;

  // request codes carried in the input tuser
  typedef logic [1:0] req_t;
  localparam req_t REQ_WRITE = 2'd0;
  localparam req_t REQ_END   = 2'd1;
  localparam req_t REQ_READ  = 2'd2;
  localparam req_t REQ_NONE  = 2'd3;

  // result kinds carried in the output tuser
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_READ = 2'd0;
  localparam kind_t KIND_ROT  = 2'd1;
  localparam kind_t KIND_TEMP = 2'd2;
  localparam kind_t KIND_VAC  = 2'd3;

  // fixed map locations
  localparam logic [MapAw-1:0] TRIG_ADDR = 8'hFF;
  localparam logic [MapAw-1:0] ROT_ADDR  = 8'd10;
  localparam logic [MapAw-1:0] TEMP_ADDR = 8'd20;
  localparam logic [MapAw-1:0] VAC_ADDR  = 8'd30;
  localparam logic [MapAw-1:0] LIVE_BASE = 8'd10;
  localparam logic [4:0]       LIVE_LAST = 5'd20;

  // trigger bits
  localparam int TRIG_ROT_BIT  = 0;
  localparam int TRIG_TEMP_BIT = 1;
  localparam int TRIG_VAC_BIT  = 2;

  localparam logic [WordW-1:0] VAC_ON = 32'd4095;

  // stream packing
  localparam int InDataW  = 152;
  localparam int InUserW  = 3;
  localparam int OutDataW = 48;

  typedef struct packed {
    req_t              req;
    logic              first;
    logic [ByteW-1:0]  data_byte;
    logic [ByteW-1:0]  read_offset;
    logic [WordW-1:0]  rot_goal;
    logic [WordW-1:0]  rot_now;
    logic [WordW-1:0]  temp_set;
    logic [WordW-1:0]  temp_now;
    logic              vacuum;
  } item_t;

  typedef struct packed {
    kind_t             kind;
    logic [ByteW-1:0]  read_data;
    logic              past_end;
    logic [WordW-1:0]  command_value;
    logic              last;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [MapAw-1:0]  waddr;
    logic [ByteW-1:0]  wdata;
    logic [MapAw-1:0]  raddr;
  } mem_bus_t;

endpackage

`default_nettype wire

@@ design/stm_ram.sv @@
`default_nettype none

module stm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/stm_ctrl.sv @@
`default_nettype none

module stm_ctrl
  import stm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire item_t            item,
  output mem_bus_t              mem,
  input  wire logic [ByteW-1:0] mem_rdata,
  output logic                  res_valid,
  output result_t               res,
  input  wire logic             res_ready
);

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b000_0000_0001,
    ST_IDLE   = 11'b000_0000_0010,
    ST_LOAD   = 11'b000_0000_0100,
    ST_RADDR  = 11'b000_0000_1000,
    ST_RDATA  = 11'b000_0001_0000,
    ST_TWAIT  = 11'b000_0010_0000,
    ST_DISP   = 11'b000_0100_0000,
    ST_GATHER = 11'b000_1000_0000,
    ST_GWAIT  = 11'b001_0000_0000,
    ST_EMIT   = 11'b010_0000_0000,
    ST_SPARE  = 11'b100_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [MapAw-1:0]  ptr_r, ptr_nxt;
  logic [MapAw-1:0]  cnt_r, cnt_nxt;
  logic [2:0]        pend_r, pend_nxt;
  logic [MapAw-1:0]  base_r, base_nxt;
  logic [WordW-1:0]  word_r, word_nxt;
  item_t             item_r;
  result_t           res_r, res_nxt;
  logic [MapAw:0]    pos;
  logic [8:0]        live;
  logic              accept;

  // live value byte for one step of the copy sweep: {write enable, byte}
  function automatic logic [8:0] live_byte(input logic [4:0] step, input item_t it);
    logic [1:0] tsel;
    tsel = step[1:0] - 2'd2;
    case (step) inside
      [5'd0:5'd3]:   live_byte = {1'b1, it.rot_goal[{step[1:0], 3'b000} +: ByteW]};
      [5'd4:5'd7]:   live_byte = {1'b1, it.rot_now[{step[1:0], 3'b000} +: ByteW]};
      [5'd10:5'd13]: live_byte = {1'b1, it.temp_set[{tsel, 3'b000} +: ByteW]};
      [5'd14:5'd17]: live_byte = {1'b1, it.temp_now[{tsel, 3'b000} +: ByteW]};
      LIVE_LAST:     live_byte = {1'b1, 7'd0, it.vacuum};
      default:       live_byte = 9'd0;
    endcase
  endfunction

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state_r == ST_EMIT);
  assign res       = res_r;
  assign pos       = {1'b0, ptr_r} + {1'b0, item_r.read_offset};
  assign live      = live_byte(cnt_r[4:0], item_r);

  // sequencer: clear the map, write bytes, copy live values, read bytes and gather commands
  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    base_nxt  = base_r;
    word_nxt  = word_r;
    res_nxt   = res_r;
    mem       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mem.we    = 1'b1;
        mem.waddr = cnt_r;
        cnt_nxt   = cnt_r + 8'd1;
        if (cnt_r == TRIG_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (item.req)
            REQ_WRITE: begin
              if (item.first) begin
                ptr_nxt = item.data_byte;
              end else begin
                mem.we    = 1'b1;
                mem.waddr = ptr_r;
                mem.wdata = item.data_byte;
                ptr_nxt   = ptr_r + 8'd1;
              end
            end
            REQ_END: begin
              mem.raddr = TRIG_ADDR;
              state_nxt = ST_TWAIT;
            end
            REQ_READ: begin
              pend_nxt  = 3'd0;
              cnt_nxt   = '0;
              state_nxt = item.first ? ST_LOAD : ST_RADDR;
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        mem.we    = live[8];
        mem.waddr = LIVE_BASE + {3'd0, cnt_r[4:0]};
        mem.wdata = live[7:0];
        cnt_nxt   = cnt_r + 8'd1;
        if (cnt_r[4:0] == LIVE_LAST) begin
          state_nxt = ST_RADDR;
        end
      end
      ST_RADDR: begin
        mem.raddr = pos[MapAw-1:0];
        if (pos[MapAw]) begin
          res_nxt   = '{kind: KIND_READ, read_data: '0, past_end: 1'b1,
                        command_value: '0, last: 1'b1};
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_RDATA;
        end
      end
      ST_RDATA: begin
        res_nxt   = '{kind: KIND_READ, read_data: mem_rdata, past_end: 1'b0,
                      command_value: '0, last: 1'b1};
        state_nxt = ST_EMIT;
      end
      ST_TWAIT: begin
        pend_nxt  = mem_rdata[2:0];
        state_nxt = ST_DISP;
      end
      ST_DISP: begin
        cnt_nxt   = '0;
        word_nxt  = '0;
        state_nxt = ST_GATHER;
        if (pend_r[TRIG_ROT_BIT]) begin
          res_nxt.kind           = KIND_ROT;
          base_nxt               = ROT_ADDR;
          pend_nxt[TRIG_ROT_BIT] = 1'b0;
        end else if (pend_r[TRIG_TEMP_BIT]) begin
          res_nxt.kind            = KIND_TEMP;
          base_nxt                = TEMP_ADDR;
          pend_nxt[TRIG_TEMP_BIT] = 1'b0;
        end else if (pend_r[TRIG_VAC_BIT]) begin
          res_nxt.kind           = KIND_VAC;
          base_nxt               = VAC_ADDR;
          pend_nxt[TRIG_VAC_BIT] = 1'b0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_GATHER: begin
        mem.raddr = base_r + cnt_r;
        state_nxt = ST_GWAIT;
      end
      ST_GWAIT: begin
        // little-endian: each byte enters at the top and shifts down
        word_nxt              = {mem_rdata, word_r[WordW-1:ByteW]};
        res_nxt.read_data     = '0;
        res_nxt.past_end      = 1'b0;
        res_nxt.last          = (pend_r == 3'd0);
        if (res_r.kind == KIND_VAC) begin
          res_nxt.command_value = (mem_rdata != '0) ? VAC_ON : '0;
          state_nxt             = ST_EMIT;
        end else if (cnt_r == 8'd3) begin
          res_nxt.command_value = word_nxt;
          state_nxt             = ST_EMIT;
        end else begin
          cnt_nxt   = cnt_r + 8'd1;
          state_nxt = ST_GATHER;
        end
      end
      ST_EMIT: begin
        if (res_ready) begin
          state_nxt = (pend_r != 3'd0) ? ST_DISP : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ptr_r   <= '0;
      cnt_r   <= '0;
      pend_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item;
    end
    base_r <= base_nxt;
    word_r <= word_nxt;
    res_r  <= res_nxt;
  end

endmodule

`default_nettype wire

@@ design/serial_target_register_map.sv @@
`default_nettype none

// Serial bus target with a 256-byte register map held in one synchronous RAM
// and an 8-bit map pointer. After reset the block clears the map with
// in_tready low. A write byte is taken while the block stays ready; a read
// byte passes an address state and a data state (only the address state when
// it falls past the map end), after a copy of live values into the map on the
// first byte of a read transfer, plus the wait for out_tready. An end of
// write reads the trigger byte, then per set trigger bit passes a dispatch
// state, an address and a data state per map byte fetched (4 bytes for
// rotation and temperature, 1 for vacuum) and an emit state to hand the result
// beat on, all through the single RAM read port; with no trigger bit set it
// ends after the dispatch state. Results pass through an output register, so
// the sequencer may prepare the next result while the previous beat waits.

module serial_target_register_map
  import stm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // data_byte[7:0], read_offset[15:8], rotation_target_live[47:16],
  // rotation_now_live[79:48], temp_setpoint_live[111:80],
  // temp_now_live[143:112], vacuum_live[144], zero fill
  input  wire logic [InDataW-1:0]  in_tdata,
  // req_type[1:0], first_of_transfer[2]
  input  wire logic [InUserW-1:0]  in_tuser,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // read_data[7:0], past_end[8], command_value[40:9], zero fill
  output logic [OutDataW-1:0]      out_tdata,
  // result_kind[1:0]
  output logic [1:0]               out_tuser,
  // last_result
  output logic                     out_tlast
);

  item_t            item;
  mem_bus_t         mem;
  logic [ByteW-1:0] mem_rdata;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             out_valid_r;
  result_t          out_r;

  // unpack the input beat
  assign item = '{req:         in_tuser[1:0],
                  first:       in_tuser[2],
                  data_byte:   in_tdata[7:0],
                  read_offset: in_tdata[15:8],
                  rot_goal:    in_tdata[47:16],
                  rot_now:     in_tdata[79:48],
                  temp_set:    in_tdata[111:80],
                  temp_now:    in_tdata[143:112],
                  vacuum:      in_tdata[144]};

  stm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .item      (item),
    .mem       (mem),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  stm_ram #(
    .Width (ByteW),
    .Depth (MapDepth)
  ) u_map (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  // pack the output beat
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r.command_value, out_r.past_end, out_r.read_data};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

endmodule

`default_nettype wire

@@ design/stm_checker.sv @@
`default_nettype none

module stm_checker
  import stm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic                in_tready,
  input  wire logic [InUserW-1:0]  in_tuser,
  input  wire logic                out_tvalid,
  input  wire logic                out_tready,
  input  wire logic [OutDataW-1:0] out_tdata,
  input  wire logic [1:0]          out_tuser,
  input  wire logic                out_tlast
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // a read result is always marked last
  a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_READ |-> out_tlast)
    else $error("read result not marked last");

  // past end only on reads, with zero data
  a_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tuser == KIND_READ && out_tdata[7:0] == 8'd0)
    else $error("bad past end result");

  // vacuum command is off or full scale
  a_vac_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_VAC |->
      out_tdata[40:9] == 32'd0 || out_tdata[40:9] == VAC_ON)
    else $error("vacuum command value out of set");

  // a read beat keeps the block busy the next cycle
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[1:0] == REQ_READ |=> !in_tready)
    else $error("ready right after a read beat");

endmodule

bind serial_target_register_map stm_checker u_stm_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import stm_pkg::*;

  localparam int HoldCycles  = 400;
  localparam int CycleLimit  = 300000;
  localparam int PhaseItems  = 120;
  localparam int SettleTicks = 100;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  // data_byte, read_offset, four live words, vacuum_live, zero fill
  logic [InDataW-1:0]  in_tdata;
  // req_type, first_of_transfer
  logic [InUserW-1:0]  in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  // read_data, past_end, command_value, zero fill
  logic [OutDataW-1:0] out_tdata;
  // result_kind
  logic [1:0]          out_tuser;
  logic                out_tlast;

  serial_target_register_map DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // shadow of the target state
  logic [ByteW-1:0] map_image [MapDepth];
  logic [MapAw-1:0] map_ptr;

  result_t expected_beats [$];
  result_t fresh_beats [$];

  int mismatches        = 0;
  int accepted_items    = 0;
  int read_beats        = 0;
  int past_end_beats    = 0;
  int command_beats     = 0;
  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;
  int hold_asks         = 0;
  int hold_seen         = 0;
  int hold_left         = 0;
  int cycle_count       = 0;

  // directed stimulus rows
  typedef struct {
    item_t            beat;
    bit               typed;
    logic [ByteW-1:0] typed_data;
    logic             typed_past;
  } stim_row_t;

  stim_row_t stim_rows [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_row(req_t r, logic f, logic [7:0] d, logic [7:0] o,
                                  logic [31:0] live, logic vac, bit typed,
                                  logic [7:0] exp_data, logic exp_past);
    stim_row_t row;
    row.beat = '{req: r, first: f, data_byte: d, read_offset: o, rot_goal: live,
                 rot_now: live, temp_set: live, temp_now: live, vacuum: vac};
    row.typed      = typed;
    row.typed_data = exp_data;
    row.typed_past = exp_past;
    stim_rows.push_back(row);
  endfunction

  function automatic logic [WordW-1:0] map_word(logic [MapAw-1:0] at);
    return {map_image[at + 8'd3], map_image[at + 8'd2],
            map_image[at + 8'd1], map_image[at]};
  endfunction

  function automatic void store_word(logic [MapAw-1:0] at, logic [WordW-1:0] w);
    for (int k = 0; k < 4; k++) map_image[at + MapAw'(k)] = w[8*k +: 8];
  endfunction

  function automatic void add_command(kind_t k, logic [WordW-1:0] value);
    fresh_beats.push_back('{kind: k, read_data: '0, past_end: 1'b0,
                            command_value: value, last: 1'b0});
  endfunction

  // next state of the map and the beats one request causes
  function automatic void predict_request(item_t it);
    logic [ByteW-1:0] trig;
    logic [MapAw:0]   pos;
    fresh_beats.delete();
    case (it.req)
      REQ_WRITE: begin
        if (it.first) begin
          map_ptr = it.data_byte;
        end else begin
          map_image[map_ptr] = it.data_byte;
          map_ptr = map_ptr + 8'd1;
        end
      end
      REQ_END: begin
        trig = map_image[TRIG_ADDR];
        if (trig[TRIG_ROT_BIT]) add_command(KIND_ROT, map_word(ROT_ADDR));
        if (trig[TRIG_TEMP_BIT]) add_command(KIND_TEMP, map_word(TEMP_ADDR));
        if (trig[TRIG_VAC_BIT])
          add_command(KIND_VAC, (map_image[VAC_ADDR] != 8'd0) ? VAC_ON : '0);
      end
      REQ_READ: begin
        if (it.first) begin
          store_word(ROT_ADDR, it.rot_goal);
          store_word(ROT_ADDR + 8'd4, it.rot_now);
          store_word(TEMP_ADDR, it.temp_set);
          store_word(TEMP_ADDR + 8'd4, it.temp_now);
          map_image[VAC_ADDR] = {7'd0, it.vacuum};
        end
        pos = {1'b0, map_ptr} + {1'b0, it.read_offset};
        if (pos[MapAw])
          fresh_beats.push_back('{kind: KIND_READ, read_data: '0, past_end: 1'b1,
                                  command_value: '0, last: 1'b0});
        else
          fresh_beats.push_back('{kind: KIND_READ, read_data: map_image[pos[MapAw-1:0]],
                                  past_end: 1'b0, command_value: '0, last: 1'b0});
      end
      default: begin
      end
    endcase
    if (fresh_beats.size() > 0) fresh_beats[fresh_beats.size() - 1].last = 1'b1;
  endfunction

  // offer one beat, then record what it should cause
  task automatic drive_beat(input item_t it, input bit typed, input result_t typed_beat);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {it.first, it.req};
    in_tdata  <= InDataW'({it.vacuum, it.temp_now, it.temp_set, it.rot_now,
                           it.rot_goal, it.read_offset, it.data_byte});
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_request(it);
    if (typed) expected_beats.push_back(typed_beat);
    else foreach (fresh_beats[i]) expected_beats.push_back(fresh_beats[i]);
    if (it.req != REQ_NONE) accepted_items++;
  endtask

  task automatic send_random(req_t r, logic f, logic [7:0] d, logic [7:0] o);
    item_t it;
    it = '{req: r, first: f, data_byte: d, read_offset: o, rot_goal: $urandom,
           rot_now: $urandom, temp_set: $urandom, temp_now: $urandom,
           vacuum: 1'($urandom_range(1))};
    drive_beat(it, 1'b0, '0);
  endtask

  // stop offering and wait until every result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // one bus transfer, mostly well formed, sometimes noise
  task automatic random_transfer();
    int choice;
    int n;
    logic [7:0] ptr;
    logic [7:0] off0;
    choice = $urandom_range(99);
    if (choice < 40) begin
      case ($urandom_range(5))
        0: ptr = TRIG_ADDR;
        1: ptr = ROT_ADDR;
        2: ptr = TEMP_ADDR;
        3: ptr = VAC_ADDR;
        4: ptr = 8'hFC;
        default: ptr = 8'($urandom_range(255));
      endcase
      send_random(REQ_WRITE, 1'b1, ptr, 8'($urandom_range(255)));
      n = $urandom_range(6);
      for (int k = 0; k < n; k++)
        send_random(REQ_WRITE, 1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)));
      if ($urandom_range(9) < 8)
        send_random(REQ_END, 1'($urandom_range(1)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
    end else if (choice < 75) begin
      n = $urandom_range(1, 5);
      off0 = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(20));
      for (int k = 0; k < n; k++)
        send_random(REQ_READ, 1'(k == 0), 8'($urandom_range(255)), off0 + 8'(k));
    end else if (choice < 85) begin
      send_random(REQ_END, 1'($urandom_range(1)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
    end else begin
      case ($urandom_range(3))
        0: send_random(REQ_NONE, 1'($urandom_range(1)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
        1: send_random(REQ_WRITE, 1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)));
        2: send_random(REQ_READ, 1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)));
        default: send_random(REQ_WRITE, 1'b1, 8'($urandom_range(255)),
                             8'($urandom_range(255)));
      endcase
    end
  endtask

  function automatic void check_field(string name, logic [WordW-1:0] want,
                                      logic [WordW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // result beat checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{kind: out_tuser, read_data: out_tdata[7:0], past_end: out_tdata[8],
              command_value: out_tdata[40:9], last: out_tlast};
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual kind %0d data %0h cmd %0h",
                 $time, got.kind, got.read_data, got.command_value);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        check_field("result_kind", WordW'(want.kind), WordW'(got.kind));
        check_field("read_data", WordW'(want.read_data), WordW'(got.read_data));
        check_field("past_end", WordW'(want.past_end), WordW'(got.past_end));
        check_field("command_value", want.command_value, got.command_value);
        check_field("last_result", WordW'(want.last), WordW'(got.last));
        if (want.kind == KIND_READ) begin
          read_beats++;
          if (want.past_end) past_end_beats++;
        end else begin
          command_beats++;
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int phase_base;
    result_t typed_beat;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b0;
    rst_n      <= 1'b0;
    for (int i = 0; i < MapDepth; i++) map_image[i] = '0;
    map_ptr = '0;

    // req, first, data, offset, live words, vacuum, typed?, data, past_end
    add_row(REQ_READ,  1'b1, 8'h00,     8'd0,   32'h0, 1'b0, 1'b1, 8'h00, 1'b0);
    add_row(REQ_READ,  1'b0, 8'h00,     8'd255, 32'h0, 1'b0, 1'b1, 8'h00, 1'b0);
    add_row(REQ_WRITE, 1'b1, TRIG_ADDR, 8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(REQ_READ,  1'b0, 8'h00,     8'd1,   32'h0, 1'b0, 1'b1, 8'h00, 1'b1);
    add_row(REQ_READ,  1'b0, 8'h00,     8'd255, 32'h0, 1'b0, 1'b1, 8'h00, 1'b1);
    add_row(REQ_END,   1'b0, 8'h00,     8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(REQ_WRITE, 1'b1, ROT_ADDR,  8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(REQ_WRITE, 1'b0, 8'h78,     8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(REQ_WRITE, 1'b0, 8'h56,     8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(REQ_WRITE, 1'b0, 8'h34,     8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(REQ_WRITE, 1'b0, 8'h12,     8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(REQ_WRITE, 1'b1, TEMP_ADDR, 8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(REQ_WRITE, 1'b0, 8'hFF,     8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(REQ_WRITE, 1'b0, 8'h00,     8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(REQ_WRITE, 1'b0, 8'hFF,     8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(REQ_WRITE, 1'b0, 8'h80,     8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(REQ_WRITE, 1'b1, VAC_ADDR,  8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(REQ_WRITE, 1'b0, 8'h01,     8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(REQ_WRITE, 1'b1, TRIG_ADDR, 8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(REQ_WRITE, 1'b0, 8'h07,     8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(REQ_END,   1'b1, 8'h00,     8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
    // pointer wrapped to zero after the trigger byte
    add_row(REQ_WRITE, 1'b0, 8'hAB,     8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(REQ_READ,  1'b1, 8'h00,     8'd9,   32'hFFFF_FFFF, 1'b1, 1'b0, 8'h00, 1'b0);
    add_row(REQ_READ,  1'b0, 8'h00,     8'd254, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'h00, 1'b0);
    add_row(REQ_NONE,  1'b1, 8'hFF,     8'd255, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'h00, 1'b0);
    add_row(REQ_END,   1'b0, 8'h00,     8'd0,   32'h0, 1'b0, 1'b0, 8'h00, 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, no idling
    foreach (stim_rows[i]) begin
      typed_beat = '{kind: KIND_READ, read_data: stim_rows[i].typed_data,
                     past_end: stim_rows[i].typed_past, command_value: '0, last: 1'b1};
      drive_beat(stim_rows[i].beat, stim_rows[i].typed, typed_beat);
    end
    drain_results();

    // random transfers over four idle and stall phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 46; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 46; end
        default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
      endcase
      phase_base = accepted_items;
      while (accepted_items - phase_base < PhaseItems) begin
        // long receiver hold-off while the sender keeps pushing
        if (phase == 0 && hold_asks == 0 && accepted_items - phase_base >= 30)
          hold_asks++;
        random_transfer();
      end
      drain_results();
    end

    repeat (SettleTicks) @(posedge clk);
    $display("ran %0d requests: %0d read beats (%0d past the map end), %0d command beats",
             accepted_items, read_beats, past_end_beats, command_beats);
    $display("phases: free running, sender gaps, receiver stalls, mixed, one long hold-off");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
